[hw/rtl/bmq_pkg.sv]
// Shared types, constants and ordering function for the bounded min queue.
package bmq_pkg;

  localparam int unsigned MAX_ENTRIES = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned WEIGHT_W    = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned COUNT_W     = 5;

  localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
  localparam logic [KIND_W-1:0] KIND_PROBE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     item_id;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [WEIGHT_W-1:0] weight;
    logic [ID_W-1:0]     item_id;
  } in_t;

  typedef struct packed {
    logic                found;
    logic                full_res;
    logic [COUNT_W-1:0]  entry_count;
    logic [WEIGHT_W-1:0] least_weight;
    logic [ID_W-1:0]     min_id;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REPLACE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

  // a orders strictly before b: lower weight, then lower id
  function automatic logic entry_before(entry_t a, entry_t b);
    logic res;
    if (a.weight != b.weight) begin
      res = a.weight < b.weight;
    end else begin
      res = a.item_id < b.item_id;
    end
    return res;
  endfunction

endpackage

[hw/rtl/bmq_cell.sv]
// One slot of the sorted entry chain: holds an entry, compares and shifts.
module bmq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic               clk_i,
  input  bmq_pkg::cell_ctrl_t ctrl_i,
  input  logic               valid_i,
  input  bmq_pkg::entry_t    left_entry_i,
  input  logic               left_lt_i,
  input  bmq_pkg::entry_t    right_entry_i,
  input  logic               right_lt_i,
  output bmq_pkg::entry_t    entry_o,
  output logic               lt_o,
  output logic               hit_o
);

  bmq_pkg::entry_t entry_q, entry_d;
  logic            lt;

  // new word sorts strictly ahead of this slot, or the slot is empty
  assign lt    = !valid_i || bmq_pkg::entry_before(ctrl_i.new_entry, entry_q);
  assign lt_o  = lt;
  assign hit_o = valid_i && (entry_q.item_id == ctrl_i.new_entry.item_id);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      bmq_pkg::CELL_INSERT: begin
        if (lt) begin
          entry_d = left_lt_i ? left_entry_i : ctrl_i.new_entry;
        end
      end
      bmq_pkg::CELL_REPLACE: begin
        // head drops out, larger entries slide down towards it
        if (!right_lt_i) begin
          entry_d = right_entry_i;
        end else if (IS_HEAD || !lt) begin
          entry_d = ctrl_i.new_entry;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[hw/rtl/bounded_top_b_min_queue.sv]
// Top level of the bounded min queue: control, count, capacity and cell chain.
//
//  channel  direction  handshake                 word
//  in       input      in_valid_i / in_ready_o   kind, weight, item_id
//  out      output     out_valid_o / out_ready_i found, full_res, entry_count,
//                                                least_weight, min_id
//  cfg      input      cfg_valid_i / cfg_ready_o capacity
//
// Each word is captured in ST_IDLE; in ST_EXEC every cell compares
// against it in parallel, the result is registered and the chain shifts.
// The next word is taken while a result waits; a stalled output holds
// ST_EXEC until the output register frees up.
// Reset empties the queue and sets capacity to sixteen; no clearing pass.
module bounded_top_b_min_queue #(
  parameter int unsigned MaxEntries = bmq_pkg::MAX_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bmq_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bmq_pkg::out_t               out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bmq_pkg::CAP_W-1:0]   cfg_data_i
);

  localparam int unsigned CntW = $clog2(MaxEntries + 1);
  localparam int unsigned ExtW = (CntW > bmq_pkg::CAP_W) ? CntW : bmq_pkg::CAP_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                    state_q, state_d;
  bmq_pkg::in_t              item_q, item_d;
  logic                      out_valid_q, out_valid_d;
  bmq_pkg::out_t             out_q, out_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [bmq_pkg::CAP_W-1:0] cap_q, cap_d;

  bmq_pkg::cell_ctrl_t       ctrl;
  bmq_pkg::entry_t           entries [MaxEntries];
  logic [MaxEntries-1:0]     lts;
  logic [MaxEntries-1:0]     hits;
  logic [MaxEntries-1:0]     valids;

  logic [ExtW-1:0]           count_ext;
  logic [ExtW-1:0]           cap_ext;
  logic [ExtW-1:0]           eff_cap;
  logic                      full;
  logic                      slot_free;
  logic                      fire;

  assign count_ext = ExtW'(count_q);
  assign cap_ext   = ExtW'(cap_q);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = ExtW'(1);
    end else if (cap_ext > ExtW'(MaxEntries)) begin
      eff_cap = ExtW'(MaxEntries);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full      = count_ext >= eff_cap;
  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = (state_q == ST_EXEC) && slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ctrl.new_entry.weight  = item_q.weight;
    ctrl.new_entry.item_id = item_q.item_id;
    if (fire && item_q.kind == bmq_pkg::KIND_INSERT) begin
      ctrl.op = full ? bmq_pkg::CELL_REPLACE : bmq_pkg::CELL_INSERT;
    end else begin
      ctrl.op = bmq_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
    bmq_pkg::entry_t left_entry, right_entry;
    logic            left_lt, right_lt;

    assign valids[i] = count_q > CntW'(i);

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_lt    = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_lt    = lts[i-1];
    end

    if (i == MaxEntries - 1) begin : g_tail
      assign right_entry = '0;
      assign right_lt    = 1'b1;
    end else begin : g_inner
      assign right_entry = entries[i+1];
      assign right_lt    = lts[i+1];
    end

    bmq_cell #(
      .IS_HEAD (i == 0)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .valid_i       (valids[i]),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .right_lt_i    (right_lt),
      .entry_o       (entries[i]),
      .lt_o          (lts[i]),
      .hit_o         (hits[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    count_d     = count_q;
    cap_d       = cap_q;

    if (cfg_valid_i) begin
      cap_d = cfg_data_i;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.found        = |hits;
          out_d.full_res     = full;
          out_d.entry_count  = count_ext[bmq_pkg::COUNT_W-1:0];
          out_d.least_weight = full ? entries[0].weight : '0;
          out_d.min_id       = full ? entries[0].item_id : '0;
          if (item_q.kind == bmq_pkg::KIND_INSERT && !full) begin
            count_d = count_q + CntW'(1);
          end else if (item_q.kind == bmq_pkg::KIND_CLEAR) begin
            count_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      count_q     <= '0;
      cap_q       <= bmq_pkg::CAP_RESET;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
    end
  end

endmodule

[bench/bounded_top_b_min_queue_tb.sv]
// Self-checking bench for the bounded min queue: directed table, random phases, live predictor.
module bounded_top_b_min_queue_tb;

  localparam int unsigned KindW      = bmq_pkg::KIND_W;
  localparam int unsigned CapW       = bmq_pkg::CAP_W;
  localparam int unsigned WeightW    = bmq_pkg::WEIGHT_W;
  localparam int unsigned IdW        = bmq_pkg::ID_W;
  localparam int unsigned CountW     = bmq_pkg::COUNT_W;
  localparam int unsigned MaxEntries = bmq_pkg::MAX_ENTRIES;

  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;
  localparam int unsigned WORDS_PER_PHASE = 200;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned LONG_HOLD = 80;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    bit                 is_cfg;
    logic [CapW-1:0]    cap;
    bmq_pkg::in_t       word;
    bit                 has_want;
    bmq_pkg::out_t      want;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  bmq_pkg::in_t     in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  bmq_pkg::out_t    out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CapW-1:0]  cfg_data_i = '0;

  // predictor state
  logic [WeightW-1:0] held_wt [MaxEntries];
  logic [IdW-1:0]     held_id [MaxEntries];
  int unsigned        held_n = 0;
  logic [CapW-1:0]    cap_setting = bmq_pkg::CAP_RESET;

  bmq_pkg::out_t owed_status [$];
  plan_row_t     plan [$];
  int unsigned   bad_fields = 0;
  int unsigned   words_seen = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   hold_ticket = 0;
  int unsigned   hold_served = 0;
  int unsigned   cycle_cnt = 0;

  bounded_top_b_min_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("bounded_top_b_min_queue verification failed");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH word %0d %s: got %0h want %0h", words_seen, what, got, want);
    bad_fields++;
  endtask

  // queue status before the word, then apply the word
  function automatic bmq_pkg::out_t min_queue_step(bmq_pkg::in_t w);
    int unsigned   lim;
    int unsigned   low;
    bit            full;
    bmq_pkg::out_t r;
    if (cap_setting == '0) lim = 1;
    else if (32'(cap_setting) > MaxEntries) lim = MaxEntries;
    else lim = 32'(cap_setting);
    full = held_n >= lim;
    low = 0;
    r = '0;
    r.full_res = full;
    r.entry_count = CountW'(held_n);
    for (int unsigned i = 0; i < held_n; i++) begin
      if (held_id[i] == w.item_id) r.found = 1'b1;
      if (held_wt[i] < held_wt[low] ||
          (held_wt[i] == held_wt[low] && held_id[i] < held_id[low])) low = i;
    end
    if (full && held_n > 0) begin
      r.least_weight = held_wt[low];
      r.min_id = held_id[low];
    end
    if (w.kind == bmq_pkg::KIND_INSERT) begin
      if (full) begin
        if (held_n > 0) begin
          held_wt[low] = w.weight;
          held_id[low] = w.item_id;
        end
      end else if (held_n < MaxEntries) begin
        held_wt[held_n] = w.weight;
        held_id[held_n] = w.item_id;
        held_n++;
      end
    end else if (w.kind == bmq_pkg::KIND_CLEAR) begin
      held_n = 0;
    end
    return r;
  endfunction

  function automatic bmq_pkg::in_t rand_word();
    bmq_pkg::in_t w;
    int unsigned  pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) w.kind = bmq_pkg::KIND_CLEAR;
    else if (pick < 58) w.kind = bmq_pkg::KIND_INSERT;
    else if (pick < 95) w.kind = bmq_pkg::KIND_PROBE;
    else w.kind = KIND_SPARE;
    pick = $urandom_range(0, 9);
    if (pick == 0) w.weight = '0;
    else if (pick == 1) w.weight = '1;
    else if (pick < 5) w.weight = WeightW'($urandom_range(0, 7));
    else w.weight = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6) w.item_id = IdW'($urandom_range(0, 15));
    else if (pick == 6) w.item_id = '1;
    else w.item_id = IdW'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic void plan_word(input logic [KindW-1:0] kind,
                                    input logic [WeightW-1:0] wt,
                                    input logic [IdW-1:0] id,
                                    input bit has_want, input bmq_pkg::out_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, cap: '0, word: '{kind: kind, weight: wt, item_id: id},
            has_want: has_want, want: want};
    plan.push_back(row);
  endfunction

  function automatic void plan_cap(input logic [CapW-1:0] v);
    plan_row_t row;
    row = '{is_cfg: 1'b1, cap: v, word: '0, has_want: 1'b0, want: '0};
    plan.push_back(row);
  endfunction

  task automatic send_word(input bmq_pkg::in_t w, input bit has_want,
                           input bmq_pkg::out_t want);
    bit            gapped;
    bmq_pkg::out_t predicted;
    gapped = 1'b0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      if (!gapped) begin
        in_valid_i <= 1'b0;
        gapped = 1'b1;
      end
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = min_queue_step(w);
    owed_status.push_back(has_want ? want : predicted);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (owed_status.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CapW-1:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cap_setting = v;
  endtask

  // receiving side: checks every accepted word, drives the stall pattern
  initial begin : rx_side
    int unsigned   hold_left;
    bmq_pkg::out_t want;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (owed_status.size() == 0) begin
          note_mismatch("word with nothing owed", out_data_o.least_weight, '0);
        end else begin
          want = owed_status.pop_front();
          if (out_data_o.found !== want.found)
            note_mismatch("found", 32'(out_data_o.found), 32'(want.found));
          if (out_data_o.full_res !== want.full_res)
            note_mismatch("full_res", 32'(out_data_o.full_res), 32'(want.full_res));
          if (out_data_o.entry_count !== want.entry_count)
            note_mismatch("entry_count", 32'(out_data_o.entry_count),
                          32'(want.entry_count));
          if (out_data_o.least_weight !== want.least_weight)
            note_mismatch("least_weight", out_data_o.least_weight, want.least_weight);
          if (out_data_o.min_id !== want.min_id)
            note_mismatch("min_id", 32'(out_data_o.min_id), 32'(want.min_id));
        end
        words_seen++;
      end
      if (hold_left == 0 && hold_served != hold_ticket) begin
        hold_left = LONG_HOLD;
        hold_served = hold_ticket;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    logic [CapW-1:0] phase_cap [NUM_PHASES];
    plan_row_t       row;
    bmq_pkg::out_t   probe_full;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    probe_full = '{found: 1'b1, full_res: 1'b1, entry_count: CountW'(3),
                   least_weight: '0, min_id: '0};
    plan_word(bmq_pkg::KIND_PROBE, '0, '0, 1'b1, '0);
    plan_word(KIND_SPARE, '1, '1, 1'b1, '0);
    plan_word(bmq_pkg::KIND_CLEAR, '0, '0, 1'b1, '0);
    plan_word(bmq_pkg::KIND_INSERT, '1, '1, 1'b0, '0);
    plan_word(bmq_pkg::KIND_INSERT, '0, '0, 1'b0, '0);
    plan_word(bmq_pkg::KIND_INSERT, '0, '0, 1'b0, '0);
    plan_word(bmq_pkg::KIND_PROBE, 32'h1234_5678, '0, 1'b0, '0);
    plan_cap(CapW'(3));
    plan_word(bmq_pkg::KIND_PROBE, '0, '1, 1'b1, probe_full);
    plan_word(bmq_pkg::KIND_INSERT, 32'd5, 16'd7, 1'b0, '0);
    plan_word(bmq_pkg::KIND_INSERT, 32'd5, 16'd3, 1'b0, '0);
    plan_word(bmq_pkg::KIND_PROBE, '0, 16'd7, 1'b0, '0);
    // capacity dropped under the held count
    plan_cap(CapW'(1));
    plan_word(bmq_pkg::KIND_INSERT, 32'd100, 16'd9, 1'b0, '0);
    plan_word(bmq_pkg::KIND_PROBE, '0, 16'd3, 1'b0, '0);
    plan_cap('0);
    plan_word(bmq_pkg::KIND_INSERT, '1, '1, 1'b0, '0);
    plan_word(bmq_pkg::KIND_CLEAR, 32'hA5A5_5A5A, 16'h5A5A, 1'b0, '0);
    plan_word(bmq_pkg::KIND_PROBE, '0, '0, 1'b1, '0);
    plan_word(bmq_pkg::KIND_INSERT, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, '0);
    plan_word(bmq_pkg::KIND_INSERT, 32'h5555_5555, 16'h5555, 1'b0, '0);
    plan_cap('1);
    plan_word(bmq_pkg::KIND_INSERT, 32'h1234_5678, 16'h5555, 1'b0, '0);
    plan_word(bmq_pkg::KIND_PROBE, '0, 16'h5555, 1'b0, '0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) set_capacity(row.cap);
      else send_word(row.word, row.has_want, row.want);
    end

    phase_cap = '{CapW'(16), CapW'(1), '1, '0, CapW'(5),
                  CapW'($urandom_range(2, 15)), CapW'(16), CapW'(3)};
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      set_capacity(phase_cap[p]);
      case (p % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 82;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 82;
        end
        default: begin
          tx_idle_pct = 17;
          rx_stall_pct = 17;
        end
      endcase
      // long receiver hold-off against a busy sender
      if (p == 4) hold_ticket++;
      for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
        if (p == 5 && n == WORDS_PER_PHASE / 2) drain();
        send_word(rand_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (owed_status.size() != 0) note_mismatch("words still owed", owed_status.size(), '0);
    if (bad_fields == 0) begin
      $display("bounded_top_b_min_queue verification clean");
    end else begin
      $display("bounded_top_b_min_queue verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bmq_pkg.sv
hw/rtl/bmq_cell.sv
hw/rtl/bounded_top_b_min_queue.sv
bench/bounded_top_b_min_queue_tb.sv
